// ===== rtl/stc_pkg.sv =====
// Shared types, codes and constants for the full-step stepper commutator.
// Used by stc_divider and stepper_full_step_commutator; no dependencies.
package stc_pkg;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY
  } stc_state_t;

  // Input command codes.
  localparam logic [1:0] CMD_MOVE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_FAILSAFE = 2'd2;

  // Move kinds.
  localparam logic [1:0] MOVE_FWD = 2'd1;
  localparam logic [1:0] MOVE_REV = 2'd2;

  // H-bridge drive codes.
  localparam logic [1:0] DRIVE_COAST = 2'd0;
  localparam logic [1:0] DRIVE_FWD   = 2'd1;
  localparam logic [1:0] DRIVE_REV   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVER_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARAMS_CONFIRM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDING_DUTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERTED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_LOSS    = 3'd5;

  // Period division: numerator fits in 26 bits, so the quotient does too.
  localparam int unsigned NUM_W = 26;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] PERIOD_NUMERATOR = 26'd60000000;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  // Full-step phase table, bridge A.
  function automatic logic [1:0] phase_drive_a(input logic [1:0] ph);
    logic [1:0] d;
    case (ph)
      2'd0:    d = DRIVE_FWD;
      2'd1:    d = DRIVE_REV;
      2'd2:    d = DRIVE_REV;
      default: d = DRIVE_FWD;
    endcase
    return d;
  endfunction

  // Full-step phase table, bridge B.
  function automatic logic [1:0] phase_drive_b(input logic [1:0] ph);
    logic [1:0] d;
    case (ph)
      2'd0:    d = DRIVE_FWD;
      2'd1:    d = DRIVE_FWD;
      2'd2:    d = DRIVE_REV;
      default: d = DRIVE_REV;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/stc_divider.sv =====
// Radix-2 restoring divider: the fixed period numerator over a 32-bit divisor.
// One quotient bit per cycle. Depends on stc_pkg.
module stc_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stc_pkg::DEN_W-1:0]      divisor,
  output logic                           done,
  output logic [stc_pkg::NUM_W-1:0]      quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [stc_pkg::CNT_W-1:0]    cnt_r;
  logic [stc_pkg::NUM_W-1:0]    num_r;
  logic [stc_pkg::NUM_W-1:0]    rem_r;
  logic [stc_pkg::NUM_W-1:0]    quo_r;
  logic [stc_pkg::DEN_W-1:0]    div_r;

  logic [stc_pkg::NUM_W-1:0]    rem_sh;
  logic [stc_pkg::NUM_W-1:0]    rem_diff;
  logic                         ge;

  // The partial remainder never exceeds the numerator, so it stays narrow.
  assign rem_sh   = {rem_r[stc_pkg::NUM_W-2:0], num_r[stc_pkg::NUM_W-1]};
  assign ge       = {{(stc_pkg::DEN_W-stc_pkg::NUM_W){1'b0}}, rem_sh} >= div_r;
  assign rem_diff = rem_sh - div_r[stc_pkg::NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= stc_pkg::CNT_W'(stc_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - stc_pkg::CNT_W'(1);
        if (cnt_r == stc_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= stc_pkg::PERIOD_NUMERATOR;
      rem_r <= '0;
      quo_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[stc_pkg::NUM_W-2:0], 1'b0};
      rem_r <= ge ? rem_diff : rem_sh;
      quo_r <= {quo_r[stc_pkg::NUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/stepper_full_step_commutator.sv =====
// Two-phase full-step commutator for a bipolar stepper on two H-bridges.
// Input transactions on in_*: in_tuser = {move_kind, command}, in_tdata =
// {time_now_us, speed_rpm}. Each input transaction gives exactly one result
// transaction on out_*: out_tuser = drive_update, out_tdata = {phase_index,
// motor_running, drive_duty, drive B, drive A}.
// Configuration must be written by the user through cfg_we/cfg_index/cfg_wdata
// only while idle; the block itself does not enforce this. Every item passes
// through one 16x16 multiply and a shared radix-2 divider that finds the step
// period one quotient bit per cycle, and a new input transaction is accepted
// only after the result of the previous one has been registered. in_tready is
// high only in the idle state; one result may wait in the output register while
// the next input transaction is accepted and worked on. If the receiver stalls,
// the new result is held back until the waiting one has been taken.
// Synchronous active-low reset: motor stopped, phase 0, step time 0, all
// configuration registers zero except stop_on_link_loss, which is set.
// Depends on stc_pkg and stc_divider.
module stepper_full_step_commutator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // speed_rpm, time_now_us
  input  logic [3:0]                       in_tuser,   // command, move_kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive A, drive B, drive_duty, motor_running, phase_index, pad
  output logic [15:0]                      out_tdata,
  output logic                             out_tuser,  // drive_update
  input  logic                             cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  stc_pkg::stc_state_t state_r, state_nxt;

  // Configuration registers.
  logic        drv_en_r;
  logic        confirmed_r;
  logic [15:0] spr_r;
  logic [6:0]  duty_r;
  logic        dir_inv_r;
  logic        stop_loss_r;

  // Latched input item.
  logic [1:0]  cmd_r;
  logic [1:0]  kind_r;
  logic [15:0] rpm_r;
  logic [31:0] now_r;

  // Motor state.
  logic        running_r, running_nxt;
  logic        reverse_r, reverse_nxt;
  logic [15:0] target_r, target_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] next_time_r, next_time_nxt;

  // Output register.
  logic        out_valid_r;
  logic        upd_r, upd_nxt;
  logic [1:0]  a_r, a_nxt;
  logic [1:0]  b_r, b_nxt;
  logic [6:0]  odu_r, odu_nxt;

  logic        den_zero_r;
  logic [15:0] rpm_sel;
  logic [stc_pkg::DEN_W-1:0] den;
  logic        div_start;
  logic        div_done;
  logic [stc_pkg::NUM_W-1:0] period;
  logic        out_free;
  logic        apply_fire;
  logic        cfg_ready;
  logic        period_zero;
  logic [31:0] diff;
  logic [6:0]  duty_sat;
  logic        step_down;

  // A move uses its own speed; a tick uses the armed speed.
  assign rpm_sel = (cmd_r == stc_pkg::CMD_MOVE) ? rpm_r : target_r;
  assign den     = 32'(rpm_sel) * 32'(spr_r);

  stc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (den),
    .done     (div_done),
    .quotient (period)
  );

  assign out_free = !out_valid_r || out_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stc_pkg::ST_IDLE:  if (in_tvalid) state_nxt = stc_pkg::ST_MUL;
      stc_pkg::ST_MUL:   state_nxt = stc_pkg::ST_DIV;
      stc_pkg::ST_DIV:   if (div_done) state_nxt = stc_pkg::ST_APPLY;
      stc_pkg::ST_APPLY: if (out_free) state_nxt = stc_pkg::ST_IDLE;
      default:           state_nxt = stc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    div_start  = 1'b0;
    apply_fire = 1'b0;
    case (state_r)
      stc_pkg::ST_IDLE:  in_tready = 1'b1;
      stc_pkg::ST_MUL:   div_start = 1'b1;
      stc_pkg::ST_APPLY: apply_fire = out_free;
      default: ;
    endcase
  end

  assign cfg_ready   = drv_en_r && confirmed_r && (spr_r != 16'd0) && (duty_r != 7'd0);
  assign period_zero = den_zero_r || (period == '0);
  assign diff        = now_r - next_time_r;
  assign duty_sat    = (duty_r > stc_pkg::DUTY_MAX) ? stc_pkg::DUTY_MAX : duty_r;
  assign step_down   = reverse_r ^ dir_inv_r;

  // Item decision: what the finished item does to the motor and the result.
  always_comb begin
    running_nxt   = running_r;
    reverse_nxt   = reverse_r;
    target_nxt    = target_r;
    phase_nxt     = phase_r;
    next_time_nxt = next_time_r;
    upd_nxt       = 1'b0;
    a_nxt         = stc_pkg::DRIVE_COAST;
    b_nxt         = stc_pkg::DRIVE_COAST;
    odu_nxt       = 7'd0;
    case (cmd_r)
      stc_pkg::CMD_MOVE: begin
        if ((kind_r == stc_pkg::MOVE_FWD || kind_r == stc_pkg::MOVE_REV) &&
            cfg_ready && !period_zero) begin
          running_nxt   = 1'b1;
          reverse_nxt   = (kind_r == stc_pkg::MOVE_REV);
          target_nxt    = rpm_r;
          next_time_nxt = now_r;
        end else begin
          running_nxt = 1'b0;
          reverse_nxt = 1'b0;
          target_nxt  = 16'd0;
          upd_nxt     = 1'b1;
        end
      end
      stc_pkg::CMD_TICK: begin
        // The step is due while the wrapped time difference is non-negative.
        if (running_r && cfg_ready && !period_zero && !diff[31]) begin
          upd_nxt       = 1'b1;
          a_nxt         = stc_pkg::phase_drive_a(phase_r);
          b_nxt         = stc_pkg::phase_drive_b(phase_r);
          odu_nxt       = duty_sat;
          phase_nxt     = step_down ? phase_r - 2'd1 : phase_r + 2'd1;
          next_time_nxt = now_r + 32'(period);
        end
      end
      stc_pkg::CMD_FAILSAFE: begin
        if (stop_loss_r) begin
          running_nxt = 1'b0;
          reverse_nxt = 1'b0;
          target_nxt  = 16'd0;
          upd_nxt     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stc_pkg::ST_IDLE;
      drv_en_r    <= 1'b0;
      confirmed_r <= 1'b0;
      spr_r       <= 16'd0;
      duty_r      <= 7'd0;
      dir_inv_r   <= 1'b0;
      stop_loss_r <= 1'b1;
      running_r   <= 1'b0;
      reverse_r   <= 1'b0;
      target_r    <= 16'd0;
      phase_r     <= 2'd0;
      next_time_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          stc_pkg::REG_DRIVER_ENABLE:  drv_en_r    <= cfg_wdata[0];
          stc_pkg::REG_PARAMS_CONFIRM: confirmed_r <= cfg_wdata[0];
          stc_pkg::REG_STEPS_PER_REV:  spr_r       <= cfg_wdata;
          stc_pkg::REG_WINDING_DUTY:   duty_r      <= cfg_wdata[6:0];
          stc_pkg::REG_DIR_INVERTED:   dir_inv_r   <= cfg_wdata[0];
          stc_pkg::REG_STOP_ON_LOSS:   stop_loss_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (apply_fire) begin
        running_r   <= running_nxt;
        reverse_r   <= reverse_nxt;
        target_r    <= target_nxt;
        phase_r     <= phase_nxt;
        next_time_r <= next_time_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser[1:0];
      kind_r <= in_tuser[3:2];
      rpm_r  <= in_tdata[15:0];
      now_r  <= in_tdata[47:16];
    end
    if (div_start) begin
      den_zero_r <= (den == '0);
    end
    if (apply_fire) begin
      upd_r <= upd_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      odu_r <= odu_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = upd_r;
  assign out_tdata  = {2'b00, phase_r, running_r, odu_r, b_r, a_r};

endmodule
